### sv/bsle_pkg.sv
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared types and constants of the byte string literal escaper.
// ----------------------------------------------------------------------------
package bsle_pkg;

   localparam int MAX_CHARS   = 6;
   localparam int CNT_W       = $clog2(MAX_CHARS + 1);
   localparam int IDX_W       = $clog2(MAX_CHARS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] QUOTE_CHAR  = 8'd34;
   localparam logic [7:0] BSLASH_CHAR = 8'd92;
   localparam logic [7:0] DIGIT_ZERO  = 8'd48;

   typedef logic [7:0] char_type;

   // One classified item: the characters it expands to, in order.
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [CNT_W-1:0]          count;
      logic                      is_end;
   } desc_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

endpackage

### sv/bsle_ifs.sv
// ----------------------------------------------------------------------------
// bsle_ifs
// Valid/ready channels for raw string bytes and escaped literal characters.
// ----------------------------------------------------------------------------
interface bsle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       is_first;
   logic       is_last;

   modport source (output valid, data_byte, has_byte, is_first, is_last, input ready);
   modport sink (input valid, data_byte, has_byte, is_first, is_last, output ready);
endinterface

interface bsle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       literal_end;

   modport source (output valid, out_char, run_last, literal_end, input ready);
   modport sink (input valid, out_char, run_last, literal_end, output ready);
endinterface

### sv/byte_string_literal_escaper_unit.sv
// The first character of an item passes through the queue entry and then the back end's
// current-item register before it can transfer out, when the back end is idle.
// Throughput: one character per cycle on the response channel while its ready is high;
// an item expands to 1 to 6 characters, up to 4 per byte.
// The two-entry queue lets the front take new items while the back is still playing out.
// Reset (synchronous, active high) empties the queue and idles the back end at once.
// ----------------------------------------------------------------------------
// byte_string_literal_escaper_unit
// Turns a stream of raw string bytes into a quoted, escaped string literal.
// ----------------------------------------------------------------------------
module byte_string_literal_escaper_unit (
   input  logic         clock,
   input  logic         reset,
   bsle_req_if.sink     req_chan,
   bsle_rsp_if.source   rsp_chan
);
   import bsle_pkg::*;

   logic       push;
   logic       pop;
   desc_type   push_desc;
   desc_type   head_desc;
   q_stat_type q_stat;

   bsle_front u_front (
      .req_chan  (req_chan),
      .q_stat    (q_stat),
      .push      (push),
      .push_desc (push_desc)
   );

   bsle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_stat    (q_stat)
   );

   bsle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_desc (head_desc),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

### sv/bsle_front.sv
// ----------------------------------------------------------------------------
// bsle_front
// Accepts input bytes and expands each one into its list of literal characters.
// ----------------------------------------------------------------------------
module bsle_front (
   bsle_req_if.sink              req_chan,
   input  bsle_pkg::q_stat_type  q_stat,
   output logic                  push,
   output bsle_pkg::desc_type    push_desc
);
   import bsle_pkg::*;

   logic [7:0]  b;
   logic [7:0]  letter;
   logic        numeric;
   logic [1:0]  hund;
   logic [7:0]  hund_x100;
   logic [6:0]  rem;
   logic [14:0] rem_scaled;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [3:0]  ones;
   logic [7:0]  esc [4];
   logic [2:0]  esc_n;
   logic [2:0]  body_n;
   logic [2:0]  pos;

   assign b = req_chan.data_byte;

   always_comb begin
      unique case (b)
         8'd34:   letter = QUOTE_CHAR;
         8'd92:   letter = BSLASH_CHAR;
         8'd7:    letter = 8'd97;   // a
         8'd8:    letter = 8'd98;   // b
         8'd12:   letter = 8'd102;  // f
         8'd10:   letter = 8'd110;  // n
         8'd13:   letter = 8'd114;  // r
         8'd9:    letter = 8'd116;  // t
         8'd11:   letter = 8'd118;  // v
         default: letter = 8'd0;
      endcase
   end

   assign numeric = (b < 8'd32) || (b > 8'd127);

   // Decimal digits: hundreds by compare, tens by a reciprocal multiply.
   assign hund       = (b >= 8'd200) ? 2'd2 : (b >= 8'd100) ? 2'd1 : 2'd0;
   assign hund_x100  = (hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0;
   assign rem        = 7'(b - hund_x100);
   assign rem_scaled = {8'd0, rem} * 15'd205;
   assign tens       = rem_scaled[14:11];
   assign tens_x10   = {3'd0, tens} * 7'd10;
   assign ones       = 4'(rem - tens_x10);

   always_comb begin
      esc[0] = b;
      esc[1] = 8'd0;
      esc[2] = 8'd0;
      esc[3] = 8'd0;
      esc_n  = 3'd1;
      if (letter != 8'd0) begin
         esc[0] = BSLASH_CHAR;
         esc[1] = letter;
         esc_n  = 3'd2;
      end else if (numeric) begin
         esc[0] = BSLASH_CHAR;
         if (b >= 8'd100) begin
            esc[1] = DIGIT_ZERO + {6'd0, hund};
            esc[2] = DIGIT_ZERO + {4'd0, tens};
            esc[3] = DIGIT_ZERO + {4'd0, ones};
            esc_n  = 3'd4;
         end else if (b >= 8'd10) begin
            esc[1] = DIGIT_ZERO + {4'd0, tens};
            esc[2] = DIGIT_ZERO + {4'd0, ones};
            esc_n  = 3'd3;
         end else begin
            esc[1] = DIGIT_ZERO + {4'd0, ones};
            esc_n  = 3'd2;
         end
      end
   end

   assign body_n = req_chan.has_byte ? esc_n : 3'd0;

   // Lay out opening quote, escaped body and closing quote in slot order.
   always_comb begin
      push_desc.is_end = req_chan.is_last;
      push_desc.count  = CNT_W'({2'd0, req_chan.is_first} + body_n
                                + {2'd0, req_chan.is_last});
      for (int j = 0; j < MAX_CHARS; j++) begin
         pos = 3'(j) - {2'd0, req_chan.is_first};
         if (req_chan.is_first && j == 0) begin
            push_desc.chars[j] = QUOTE_CHAR;
         end else if (pos < body_n) begin
            push_desc.chars[j] = esc[pos[1:0]];
         end else if (req_chan.is_last && pos == body_n) begin
            push_desc.chars[j] = QUOTE_CHAR;
         end else begin
            push_desc.chars[j] = 8'd0;
         end
      end
   end

   assign req_chan.ready = !q_stat.full;
   // Items that expand to nothing are accepted and dropped here.
   assign push = req_chan.valid && req_chan.ready && (push_desc.count != '0);

endmodule

### sv/bsle_queue.sv
// ----------------------------------------------------------------------------
// bsle_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bsle_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bsle_pkg::desc_type    push_desc,
   input  logic                  pop,
   output bsle_pkg::desc_type    head_desc,
   output bsle_pkg::q_stat_type  q_stat
);
   import bsle_pkg::*;

   desc_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign q_stat.full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.not_empty = (cnt_ff != '0);
   assign head_desc        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full && !pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.not_empty)
      else $error("queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + QCNT_W'(1)))
      else $error("queue count did not advance on a write");

endmodule

### sv/bsle_back.sv
// ----------------------------------------------------------------------------
// bsle_back
// Plays out the characters of each classified item, one per cycle while the response channel is ready.
// ----------------------------------------------------------------------------
module bsle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bsle_pkg::desc_type    head_desc,
   input  bsle_pkg::q_stat_type  q_stat,
   output logic                  pop,
   bsle_rsp_if.source            rsp_chan
);
   import bsle_pkg::*;

   desc_type         cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             at_end;
   logic             xfer;

   assign xfer   = rsp_chan.valid && rsp_chan.ready;
   assign at_end = (CNT_W'(idx_ff) + CNT_W'(1) == cur_ff.count);
   // A new item is loaded when idle or in the cycle the last character leaves.
   assign pop    = q_stat.not_empty && (!busy_ff || (xfer && at_end));

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop) begin
         cur_in  = head_desc;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (xfer) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.out_char    = cur_ff.chars[idx_ff];
   assign rsp_chan.run_last    = at_end;
   assign rsp_chan.literal_end = at_end && cur_ff.is_end;

   a_end_is_quote: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.literal_end) |->
         (rsp_chan.run_last && rsp_chan.out_char == QUOTE_CHAR))
      else $error("literal end not on a closing quote");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (CNT_W'(idx_ff) < cur_ff.count))
      else $error("character index beyond item length");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (xfer && !at_end) |=> (busy_ff && idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("character index did not advance after a transfer");

endmodule
